// ===== rtl/rbt_pkg.sv =====
// Shared types and constants for the record byte transposer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rbt_pkg;

   localparam int DATA_W          = 8;
   localparam int RS_W            = 7;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 7;
   localparam int BLOCK_BYTES_DEF = 4096;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIRECTION   = 1'b0,
      REG_RECORD_SIZE = 1'b1
   } csr_reg_type;

   localparam logic OP_LOAD         = 1'b0;
   localparam logic OP_DRAIN        = 1'b1;
   localparam logic DIR_FORWARD     = 1'b0;
   localparam logic DIR_REVERSE     = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_SIZE = 1'b1;

   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] data_in;
      logic              last_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              last_out;
      logic              status;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_CLOSE,
      CMD_DRAIN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [DATA_W-1:0] data;
   } cmd_type;

endpackage

// ===== rtl/rbt_front.sv =====
// Front end of the transposer: accepts request transactions, classifies them
// and holds them in a short command queue. Depends on rbt_pkg.
`timescale 1ns / 1ps

module rbt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbt_pkg::req_type req_data,
   output logic             cmd_valid,
   output rbt_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import rbt_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         queue_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   cmd_type         new_cmd;
   logic            push;

   assign req_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.data = req_data.data_in;
      case (req_data.op)
         OP_LOAD:  new_cmd.kind = req_data.last_in ? CMD_CLOSE : CMD_LOAD;
         OP_DRAIN: new_cmd.kind = CMD_DRAIN;
         default:  new_cmd.kind = CMD_DRAIN;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[AW-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/rbt_div.sv =====
// Restoring divider that yields the plane length of a closed block, one
// quotient bit per cycle. Depends on rbt_pkg.
`timescale 1ns / 1ps

module rbt_div #(
   parameter int LEN_W = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [LEN_W-1:0]         dividend,
   input  logic [rbt_pkg::RS_W-1:0] divisor,
   output logic                     done,
   output logic [LEN_W-1:0]         quotient,
   output logic [rbt_pkg::RS_W-1:0] remainder
);
   import rbt_pkg::*;

   localparam int CNT_W = $clog2(LEN_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   quot_ff, quot_in;
   logic [RS_W-1:0]    rem_ff, rem_in;
   logic [RS_W-1:0]    divisor_ff, divisor_in;
   logic [RS_W:0]      trial;
   logic [RS_W:0]      diff;
   logic               fits;

   always_comb begin
      trial = {rem_ff, quot_ff[LEN_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(LEN_W);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[LEN_W-2:0], fits};
         rem_in  = fits ? diff[RS_W-1:0] : trial[RS_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/rbt_back.sv =====
// Back end of the transposer: block store, block close with plane length
// division, and address sequencing for the drain. Depends on rbt_pkg, rbt_div.
`timescale 1ns / 1ps

module rbt_back #(
   parameter int BLOCK_BYTES = rbt_pkg::BLOCK_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  rbt_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   input  logic                     cfg_direction,
   input  logic [rbt_pkg::RS_W-1:0] cfg_record_size,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rbt_pkg::rsp_type         rsp_data
);
   import rbt_pkg::*;

   localparam int LEN_W  = $clog2(BLOCK_BYTES + 1);
   localparam int ADDR_W = $clog2(BLOCK_BYTES);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   body_ff, body_in;
   logic [LEN_W-1:0]   step_ff, step_in;
   logic [LEN_W-1:0]   wrap_ff, wrap_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   inner_ff, inner_in;
   logic [LEN_W-1:0]   outer_ff, outer_in;
   logic [LEN_W-1:0]   src_ff, src_in;
   logic               dir_ff, dir_in;
   logic [RS_W-1:0]    size_ff, size_in;
   logic               xpose_ff, xpose_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic               rd_status_ff, rd_status_in;
   logic               out_vld_ff, out_vld_in;
   rsp_type            out_ff, out_in;

   logic [DATA_W-1:0]  mem [BLOCK_BYTES];
   logic [DATA_W-1:0]  rd_data_ff;

   logic               out_take;
   logic               rd_free;
   logic               wr_en;
   logic               rd_en;
   logic [LEN_W-1:0]   addr_sel;
   logic               final_byte;
   logic               div_start;
   logic               div_done;
   logic [LEN_W-1:0]   div_quot;
   logic [RS_W-1:0]    div_rem;

   rbt_div #(
      .LEN_W(LEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (len_in),
      .divisor   (size_in),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      out_take   = !out_vld_ff || rsp_ready;
      rd_free    = !rd_vld_ff || out_take;
      // Inside the record body the transposed address is used; the tail
      // past the last whole record, and untransposed blocks, read in place.
      addr_sel   = (xpose_ff && (pos_ff < body_ff)) ? src_ff : pos_ff;
      final_byte = ((pos_ff + LEN_W'(1)) == len_ff);

      state_in     = state_ff;
      len_in       = len_ff;
      body_in      = body_ff;
      step_in      = step_ff;
      wrap_in      = wrap_ff;
      pos_in       = pos_ff;
      inner_in     = inner_ff;
      outer_in     = outer_ff;
      src_in       = src_ff;
      dir_in       = dir_ff;
      size_in      = size_ff;
      xpose_in     = xpose_ff;
      rd_vld_in    = rd_vld_ff;
      rd_last_in   = rd_last_ff;
      rd_status_in = rd_status_ff;
      out_vld_in   = out_vld_ff;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;

      if (out_take) begin
         out_vld_in      = rd_vld_ff;
         out_in.data_out = rd_data_ff;
         out_in.last_out = rd_last_ff;
         out_in.status   = rd_status_ff;
      end
      if (rd_free) begin
         rd_vld_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind inside {CMD_LOAD, CMD_CLOSE}) begin
                  // Bytes beyond the store are dropped, but a close still counts.
                  if (len_ff != LEN_W'(BLOCK_BYTES)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (cmd.kind == CMD_CLOSE) begin
                     dir_in    = cfg_direction;
                     size_in   = cfg_record_size;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               xpose_in = (size_ff > RS_W'(1)) && (div_quot != '0);
               body_in  = len_ff - LEN_W'(div_rem);
               if (dir_ff == DIR_REVERSE) begin
                  step_in = div_quot;
                  wrap_in = LEN_W'(size_ff) - LEN_W'(1);
               end else begin
                  step_in = LEN_W'(size_ff);
                  wrap_in = div_quot - LEN_W'(1);
               end
               pos_in   = '0;
               inner_in = '0;
               outer_in = '0;
               src_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_DRAIN) begin
                  if (rd_free) begin
                     cmd_pop      = 1'b1;
                     rd_en        = 1'b1;
                     rd_vld_in    = 1'b1;
                     rd_last_in   = final_byte;
                     rd_status_in = (size_ff == '0) ? STATUS_BAD_SIZE : STATUS_OK;
                     pos_in       = pos_ff + LEN_W'(1);
                     if (inner_ff == wrap_ff) begin
                        inner_in = '0;
                        outer_in = outer_ff + LEN_W'(1);
                        src_in   = outer_ff + LEN_W'(1);
                     end else begin
                        inner_in = inner_ff + LEN_W'(1);
                        src_in   = src_ff + step_ff;
                     end
                     if (final_byte) begin
                        len_in   = '0;
                        state_in = ST_LOAD;
                     end
                  end
               end else begin
                  // Loads are ignored until the block has been drained.
                  cmd_pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         len_ff     <= '0;
         pos_ff     <= '0;
         inner_ff   <= '0;
         outer_ff   <= '0;
         src_ff     <= '0;
         dir_ff     <= DIR_FORWARD;
         size_ff    <= RS_W'(1);
         xpose_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         pos_ff     <= pos_in;
         inner_ff   <= inner_in;
         outer_ff   <= outer_in;
         src_ff     <= src_in;
         dir_ff     <= dir_in;
         size_ff    <= size_in;
         xpose_ff   <= xpose_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
      body_ff      <= body_in;
      step_ff      <= step_in;
      wrap_ff      <= wrap_in;
      rd_last_ff   <= rd_last_in;
      rd_status_ff <= rd_status_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[len_ff[ADDR_W-1:0]] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_sel[ADDR_W-1:0]];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff && !out_take |=> rd_vld_ff && $stable(rd_data_ff))
      else $error("read data lost while the output register was full");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> pos_ff < len_ff)
      else $error("drain position ran past the block length");

   a_body_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN && xpose_ff |-> body_ff <= len_ff && body_ff != '0)
      else $error("record body inconsistent with block length");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> state_ff == ST_DRAIN && addr_sel < len_ff)
      else $error("drain read outside the loaded block");

endmodule

// ===== rtl/record_byte_transpose.sv =====
// Record byte transposer: each load transaction stores one byte, each drain
// transaction returns one byte of the reordered block, one per cycle each
// while no rsp back-pressure or block close holds them. A drain result
// passes the command queue, store read register and output register to rsp.
// A close runs the bit-serial plane length division before any drain is served.
// Synchronous active-high reset empties the block and sets record size 1.
`timescale 1ns / 1ps

module record_byte_transpose #(
   parameter int BLOCK_BYTES = rbt_pkg::BLOCK_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rbt_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rbt_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [rbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rbt_pkg::*;

   logic            direction_ff, direction_in;
   logic [RS_W-1:0] record_size_ff, record_size_in;
   logic            cmd_valid;
   cmd_type         cmd;
   logic            cmd_pop;

   always_comb begin
      direction_in   = direction_ff;
      record_size_in = record_size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_DIRECTION:   direction_in   = csr_wdata[0];
            REG_RECORD_SIZE: record_size_in = csr_wdata[RS_W-1:0];
            default: begin
               direction_in = direction_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= DIR_FORWARD;
         record_size_ff <= RS_W'(1);
      end else begin
         direction_ff   <= direction_in;
         record_size_ff <= record_size_in;
      end
   end

   rbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   rbt_back #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .cfg_direction   (direction_ff),
      .cfg_record_size (record_size_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule
